### rtl/rrss_pkg.sv
// Package: shared types, codes and defaults for the round-robin slice scheduler.
`timescale 1ns / 1ps
package rrss_pkg;

	localparam int RRSS_MAX_JOBS = 16;

	localparam int QUANTUM_W = 16;
	localparam int ID_W      = 16;
	localparam int BURST_W   = 16;
	localparam int CLOCK_W   = 20;
	localparam int SUM_W     = 24;

	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd4;

	// request function codes
	localparam logic [1:0] FN_LOAD  = 2'd0;
	localparam logic [1:0] FN_STEP  = 2'd1;
	localparam logic [1:0] FN_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic [ID_W-1:0]    job_id;
		logic [BURST_W-1:0] burst;
	} req_t;

	typedef struct packed {
		logic               slice_valid;
		logic [ID_W-1:0]    slice_job;
		logic [CLOCK_W-1:0] slice_start;
		logic [CLOCK_W-1:0] slice_end;
		logic               job_finished;
		logic               all_done;
		logic [SUM_W-1:0]   total_wait;
		logic [SUM_W-1:0]   total_turnaround;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC,
		ST_FIN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_job;
		logic clear;
		logic step_none;
		logic scan_init;
		logic scan_adv;
		logic exec;
		logic finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;     // no unfinished job
		logic hit;       // entry under scan is pending
		logic out_busy;  // result register full and stalled
	} stat_t;

endpackage

### rtl/rrss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rrss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/rrss_ctrl.sv
// Controller state machine: request handshake and step sequencing.
`timescale 1ns / 1ps
module rrss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  logic [1:0]     func,
	input  rrss_pkg::stat_t stat,
	output rrss_pkg::cmd_t  cmd
);
	import rrss_pkg::*;

	state_t state_q, state_nxt;
	logic   accept;

	assign req_stall = (state_q != ST_IDLE) || ((func == FN_STEP) && stat.out_busy);
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (func == FN_STEP) && !stat.empty) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.hit) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: state_nxt = ST_FIN;
			ST_FIN:  state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_job  = (func == FN_LOAD);
					cmd.clear     = (func == FN_CLEAR);
					cmd.step_none = (func == FN_STEP) && stat.empty;
					cmd.scan_init = (func == FN_STEP) && !stat.empty;
				end
			end
			ST_SCAN: cmd.scan_adv = !stat.hit;
			ST_EXEC: cmd.exec     = 1'b1;
			ST_FIN:  cmd.finish   = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

### rtl/rrss_dp.sv
// Datapath: job tables, pending bits, clock, totals and result register.
`timescale 1ns / 1ps
module rrss_dp #(
	parameter int MAX_JOBS = rrss_pkg::RRSS_MAX_JOBS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rrss_pkg::req_t                     req,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [rrss_pkg::QUANTUM_W-1:0]     cfg_data,
	input  rrss_pkg::cmd_t                     cmd,
	output rrss_pkg::stat_t                    stat,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output rrss_pkg::rsp_t                     rsp
);
	import rrss_pkg::*;

	localparam int IW = $clog2(MAX_JOBS);
	localparam int CW = $clog2(MAX_JOBS + 1);

	logic [QUANTUM_W-1:0] quantum_q;
	logic [CW-1:0]        job_count_q;
	logic [CW-1:0]        unfinished_q;
	logic [IW-1:0]        next_index_q;
	logic [IW-1:0]        scan_q;
	logic [MAX_JOBS-1:0]  pending_q;
	logic [CLOCK_W-1:0]   clock_q;
	logic [SUM_W-1:0]     wait_sum_q;
	logic [SUM_W-1:0]     turn_sum_q;
	logic [CLOCK_W-1:0]   start_q;
	logic                 fin_q;
	logic                 out_valid_q;
	rsp_t                 rsp_q;

	logic                 full;
	logic                 load_ok;
	logic [IW-1:0]        scan_start;
	logic [IW-1:0]        scan_next;
	logic [IW-1:0]        load_addr;

	logic [ID_W+BURST_W-1:0] idb_rd;
	logic [BURST_W-1:0]      rem_rd;
	logic                    rem_we;
	logic [IW-1:0]           rem_waddr;
	logic [BURST_W-1:0]      rem_wdata;

	logic [QUANTUM_W-1:0] q_eff;
	logic [BURST_W-1:0]   run;
	logic [BURST_W-1:0]   rem_new;
	logic [CLOCK_W:0]     clk_sum;
	logic [CLOCK_W-1:0]   clock_new;

	logic [CLOCK_W-1:0]   wait_term;
	logic [SUM_W:0]       turn_add;
	logic [SUM_W:0]       wait_add;
	logic [SUM_W-1:0]     turn_new;
	logic [SUM_W-1:0]     wait_new;

	assign full      = (job_count_q == CW'(MAX_JOBS));
	assign load_ok   = cmd.load_job && !full;
	assign load_addr = job_count_q[IW-1:0];

	// next_index wraps at job_count
	assign scan_start = ({1'b0, next_index_q} >= (IW+1)'(job_count_q)) ? '0 : next_index_q;
	assign scan_next  = ((IW+1)'(scan_q) + (IW+1)'(1) >= (IW+1)'(job_count_q)) ?
	                    '0 : scan_q + IW'(1);

	assign stat.empty    = (unfinished_q == '0);
	assign stat.hit      = pending_q[scan_q];
	assign stat.out_busy = out_valid_q && rsp_stall;

	// tables
	rrss_ram #(.WIDTH(ID_W + BURST_W), .DEPTH(MAX_JOBS)) u_idb_ram (
		.clk   (clk),
		.we    (load_ok),
		.waddr (load_addr),
		.wdata ({req.job_id, req.burst}),
		.raddr (scan_q),
		.rdata (idb_rd)
	);

	assign rem_we    = load_ok || cmd.exec;
	assign rem_waddr = cmd.exec ? scan_q : load_addr;
	assign rem_wdata = cmd.exec ? rem_new : req.burst;

	rrss_ram #(.WIDTH(BURST_W), .DEPTH(MAX_JOBS)) u_rem_ram (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.raddr (scan_q),
		.rdata (rem_rd)
	);

	// slice: run = min(remaining, quantum), clock saturates
	assign q_eff     = (quantum_q == '0) ? QUANTUM_W'(1) : quantum_q;
	assign run       = (rem_rd < q_eff) ? rem_rd : q_eff;
	assign rem_new   = rem_rd - run;
	assign clk_sum   = {1'b0, clock_q} + (CLOCK_W+1)'(run);
	assign clock_new = clk_sum[CLOCK_W] ? '1 : clk_sum[CLOCK_W-1:0];

	// totals on finish; clock_q already holds the finish time here
	assign wait_term = (clock_q > CLOCK_W'(idb_rd[BURST_W-1:0])) ?
	                   clock_q - CLOCK_W'(idb_rd[BURST_W-1:0]) : '0;
	assign turn_add  = {1'b0, turn_sum_q} + (SUM_W+1)'(clock_q);
	assign wait_add  = {1'b0, wait_sum_q} + (SUM_W+1)'(wait_term);
	assign turn_new  = !fin_q ? turn_sum_q : (turn_add[SUM_W] ? '1 : turn_add[SUM_W-1:0]);
	assign wait_new  = !fin_q ? wait_sum_q : (wait_add[SUM_W] ? '1 : wait_add[SUM_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q    <= QUANTUM_RESET;
			job_count_q  <= '0;
			unfinished_q <= '0;
			next_index_q <= '0;
			scan_q       <= '0;
			pending_q    <= '0;
			clock_q      <= '0;
			wait_sum_q   <= '0;
			turn_sum_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				quantum_q <= cfg_data;
			end
			if (load_ok) begin
				job_count_q          <= job_count_q + CW'(1);
				pending_q[load_addr] <= (req.burst != '0);
				if (req.burst != '0) begin
					unfinished_q <= unfinished_q + CW'(1);
				end
			end
			if (cmd.clear) begin
				job_count_q  <= '0;
				unfinished_q <= '0;
				next_index_q <= '0;
				clock_q      <= '0;
				wait_sum_q   <= '0;
				turn_sum_q   <= '0;
			end
			if (cmd.scan_init) begin
				scan_q <= scan_start;
			end
			if (cmd.scan_adv) begin
				scan_q <= scan_next;
			end
			if (cmd.exec) begin
				clock_q      <= clock_new;
				next_index_q <= scan_next;
				if (rem_new == '0) begin
					pending_q[scan_q] <= 1'b0;
					unfinished_q      <= unfinished_q - CW'(1);
				end
			end
			if (cmd.finish) begin
				wait_sum_q <= wait_new;
				turn_sum_q <= turn_new;
			end
			if (cmd.step_none || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			start_q <= clock_q;
			fin_q   <= (rem_new == '0);
		end
		if (cmd.step_none) begin
			rsp_q.slice_valid      <= 1'b0;
			rsp_q.slice_job        <= '0;
			rsp_q.slice_start      <= clock_q;
			rsp_q.slice_end        <= clock_q;
			rsp_q.job_finished     <= 1'b0;
			rsp_q.all_done         <= 1'b1;
			rsp_q.total_wait       <= wait_sum_q;
			rsp_q.total_turnaround <= turn_sum_q;
		end else if (cmd.finish) begin
			rsp_q.slice_valid      <= 1'b1;
			rsp_q.slice_job        <= idb_rd[ID_W+BURST_W-1:BURST_W];
			rsp_q.slice_start      <= start_q;
			rsp_q.slice_end        <= clock_q;
			rsp_q.job_finished     <= fin_q;
			rsp_q.all_done         <= (unfinished_q == '0);
			rsp_q.total_wait       <= wait_new;
			rsp_q.total_turnaround <= turn_new;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/round_robin_slice_scheduler_unit.sv
// Top level: round-robin time-slice scheduler with a programmable quantum.
`timescale 1ns / 1ps
// Usage:
//   req channel (req_valid / req_stall / req): one transaction per request.
//     func FN_LOAD appends (job_id, burst) to the job table, FN_CLEAR restarts
//     table, clock and totals, FN_STEP runs the next unfinished job in
//     circular order for min(remaining, quantum). Code 3 is dropped.
//   rsp channel (rsp_valid / rsp_stall / rsp): one transaction per step.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): quantum register, always
//     ready; write it only while the block is idle. Quantum 0 runs as 1.
// Timing:
//   Load and clear take effect at the edge that accepts them. A step passes
//   through ST_SCAN, ST_EXEC and ST_FIN to its result; ST_SCAN steps over the
//   finished table entries from next_index, one pending bit per cycle. A step
//   with nothing left to run answers in the next cycle. One step is in flight
//   at a time; no request is taken until its result is registered.
// Reset: quantum 4, empty table, clock and totals zero; no clearing pass.
// Stall: the result register holds under rsp_stall; loads and clears still
//   go in, a step waits on req_stall until the result register can take it.
module round_robin_slice_scheduler_unit #(
	parameter int MAX_JOBS = rrss_pkg::RRSS_MAX_JOBS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  rrss_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output rrss_pkg::rsp_t                 rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rrss_pkg::QUANTUM_W-1:0] cfg_data
);
	import rrss_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// quantum register takes a write in any cycle
	assign cfg_ready = 1'b1;

	rrss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.func      (req.func),
		.stat      (stat),
		.cmd       (cmd)
	);

	rrss_dp #(.MAX_JOBS(MAX_JOBS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### dv/tb_round_robin_slice_scheduler_unit.sv
// Testbench: self-checking run of the round-robin slice scheduler against a predictor.
`timescale 1ns / 1ps
module tb_round_robin_slice_scheduler_unit;
	import rrss_pkg::*;

	localparam int MAX_JOBS = RRSS_MAX_JOBS;
	localparam int unsigned CLOCK_MAX = (1 << CLOCK_W) - 1;
	localparam int unsigned SUM_MAX = (1 << SUM_W) - 1;
	// idle cycles after the last result before the quantum may change
	localparam int SETTLE_CYCLES = 24;
	// longest legal silence is the long receiver hold (HOLD_CYCLES) plus a step
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AT = 300;
	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 85;
	localparam int STEP_CAP = 60;
	localparam logic [1:0] FN_UNUSED = 2'd3;

	typedef struct {
		req_t rq;
		bit   fixed;
		rsp_t want;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b1;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [QUANTUM_W-1:0] cfg_data = '0;

	round_robin_slice_scheduler_unit #(
		.MAX_JOBS(MAX_JOBS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor state: job table, rotation pointer, clock and totals
	// ---------------------------------------------------------------
	logic [ID_W-1:0]      job_tag  [MAX_JOBS];
	logic [BURST_W-1:0]   job_len  [MAX_JOBS];
	logic [BURST_W-1:0]   job_left [MAX_JOBS];
	int unsigned          jobs_loaded = 0;
	int unsigned          rr_ptr = 0;
	logic [CLOCK_W-1:0]   sched_now = '0;
	logic [SUM_W-1:0]     wait_total = '0;
	logic [SUM_W-1:0]     tat_total = '0;
	logic [QUANTUM_W-1:0] quantum_reg = QUANTUM_RESET;

	rsp_t pending_slices[$];
	int   mismatches = 0;
	int   items_sent = 0;
	int   slices_seen = 0;
	int   quiet_cycles = 0;
	bit   calm = 1'b0;

	// Applies one request to the predicted state; returns 1 when a slice
	// report is due, with the expected report in o.
	function automatic bit rr_schedule(input req_t r, output rsp_t o);
		int unsigned k, j, idx, qe, run, t, w;
		bit found;
		o = '0;
		found = 1'b0;
		idx = 0;
		unique case (r.func)
			FN_LOAD: begin
				// table full: load dropped
				if (jobs_loaded < MAX_JOBS) begin
					job_tag[jobs_loaded]  = r.job_id;
					job_len[jobs_loaded]  = r.burst;
					job_left[jobs_loaded] = r.burst;
					jobs_loaded++;
				end
				return 1'b0;
			end
			FN_CLEAR: begin
				jobs_loaded = 0;
				rr_ptr = 0;
				sched_now = '0;
				wait_total = '0;
				tat_total = '0;
				return 1'b0;
			end
			FN_STEP: begin
				if (rr_ptr >= jobs_loaded)
					rr_ptr = 0;
				for (k = 0; k < jobs_loaded && !found; k++) begin
					j = rr_ptr + k;
					if (j >= jobs_loaded)
						j -= jobs_loaded;
					if (job_left[j] != 0) begin
						idx = j;
						found = 1'b1;
					end
				end
				o.slice_start = sched_now;
				if (found) begin
					qe = (quantum_reg == 0) ? 1 : 32'(quantum_reg);
					run = (32'(job_left[idx]) < qe) ? 32'(job_left[idx]) : qe;
					job_left[idx] = job_left[idx] - BURST_W'(run);
					t = sched_now + run;
					sched_now = (t > CLOCK_MAX) ? CLOCK_MAX[CLOCK_W-1:0] : t[CLOCK_W-1:0];
					if (job_left[idx] == 0) begin
						// waiting is finish minus burst, floored at zero
						w = (sched_now > job_len[idx]) ? sched_now - job_len[idx] : 0;
						o.job_finished = 1'b1;
						t = tat_total + sched_now;
						tat_total = (t > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : t[SUM_W-1:0];
						t = wait_total + w;
						wait_total = (t > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : t[SUM_W-1:0];
					end
					rr_ptr = idx + 1;
					if (rr_ptr >= jobs_loaded)
						rr_ptr = 0;
					o.slice_job = job_tag[idx];
				end
				o.slice_valid = found;
				o.slice_end = sched_now;
				o.all_done = 1'b1;
				for (k = 0; k < jobs_loaded; k++)
					if (job_left[k] != 0)
						o.all_done = 1'b0;
				o.total_wait = wait_total;
				o.total_turnaround = tat_total;
				return 1'b1;
			end
			default: return 1'b0;  // unused code dropped
		endcase
	endfunction

	function automatic req_t mk_req(input logic [1:0] f, input logic [15:0] id,
			input logic [15:0] b);
		req_t r;
		r.func = f;
		r.job_id = id;
		r.burst = b;
		return r;
	endfunction

	// report for a step that finds nothing to run right after a restart
	function automatic rsp_t idle_rsp();
		rsp_t o;
		o = '0;
		o.all_done = 1'b1;
		return o;
	endfunction

	// bursts scaled to the quantum so most job sets run to completion
	function automatic logic [15:0] pick_burst(input int unsigned qe);
		if (qe >= 4096 || $urandom_range(0, 15) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 3 * qe));
	endfunction

	// ---------------------------------------------------------------
	// Request side: per-transaction gap, then hold valid until taken
	// ---------------------------------------------------------------
	task automatic send_req(input req_t r, input bit fixed, input rsp_t want);
		int gap;
		rsp_t pred;
		gap = calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		// transaction accepted at this edge
		if (r.func != FN_UNUSED)
			items_sent++;
		if (rr_schedule(r, pred))
			pending_slices.push_back(fixed ? want : pred);
	endtask

	task automatic send(input req_t r);
		send_req(r, 1'b0, '0);
	endtask

	// wait for every expected report, then let the block settle
	task automatic drain();
		req_valid <= 1'b0;
		while (pending_slices.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_quantum(input logic [QUANTUM_W-1:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		quantum_reg = v;
	endtask

	// ---------------------------------------------------------------
	// Response side: per-transaction stall, one long hold mid-run
	// ---------------------------------------------------------------
	task automatic cmp_field(input string name, input logic [SUM_W-1:0] want,
			input logic [SUM_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %h got %h", $realtime, name, want, got);
		end
	endtask

	task automatic check_slice(input rsp_t got);
		rsp_t want;
		if (pending_slices.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected report %h", $realtime, got);
			return;
		end
		want = pending_slices.pop_front();
		cmp_field("slice_valid", SUM_W'(want.slice_valid), SUM_W'(got.slice_valid));
		cmp_field("slice_job", SUM_W'(want.slice_job), SUM_W'(got.slice_job));
		cmp_field("slice_start", SUM_W'(want.slice_start), SUM_W'(got.slice_start));
		cmp_field("slice_end", SUM_W'(want.slice_end), SUM_W'(got.slice_end));
		cmp_field("job_finished", SUM_W'(want.job_finished), SUM_W'(got.job_finished));
		cmp_field("all_done", SUM_W'(want.all_done), SUM_W'(got.all_done));
		cmp_field("total_wait", want.total_wait, got.total_wait);
		cmp_field("total_turnaround", want.total_turnaround, got.total_turnaround);
	endtask

	initial begin
		int n;
		@(posedge clk);
		forever begin
			// the long hold backs the block up until it stalls its input
			if (slices_seen == HOLD_AT)
				n = HOLD_CYCLES;
			else
				n = calm ? 0 : $urandom_range(0, 15);
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			check_slice(rsp);
			slices_seen++;
		end
	end

	// watchdog: any accepted transaction on any channel counts as progress
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence: directed table, then random phases per quantum
	// ---------------------------------------------------------------
	initial begin
		dir_row_t dir_tbl[$];
		dir_row_t row;
		rsp_t busy;
		logic [QUANTUM_W-1:0] qv;
		int unsigned qe, need, n_load, n_step;
		int phase_start;
		logic [15:0] b;

		// directed table; typed expectations only where obvious
		row.fixed = 1'b1;
		row.want = idle_rsp();
		row.rq = mk_req(FN_STEP, 16'h0000, 16'h0000);  // step on an empty table
		dir_tbl.push_back(row);
		row.fixed = 1'b0;
		row.rq = mk_req(FN_LOAD, 16'hFFFF, 16'h0000);  // zero burst: done at once
		dir_tbl.push_back(row);
		row.fixed = 1'b1;
		row.rq = mk_req(FN_STEP, 16'h0000, 16'h0000);  // nothing left to run
		dir_tbl.push_back(row);
		row.fixed = 1'b0;
		row.rq = mk_req(FN_LOAD, 16'h0000, 16'hFFFF);  // longest burst
		dir_tbl.push_back(row);
		row.rq = mk_req(FN_LOAD, 16'h1234, 16'h0001);
		dir_tbl.push_back(row);
		busy = '0;
		busy.slice_valid = 1'b1;
		busy.slice_end = CLOCK_W'(4);  // reset quantum, skips the zero-burst entry
		row.fixed = 1'b1;
		row.want = busy;
		row.rq = mk_req(FN_STEP, 16'h0000, 16'h0000);
		dir_tbl.push_back(row);
		row.fixed = 1'b0;
		row.rq = mk_req(FN_STEP, 16'h0000, 16'h0000);
		dir_tbl.push_back(row);
		row.rq = mk_req(FN_UNUSED, 16'hAAAA, 16'h5555);  // dropped code
		dir_tbl.push_back(row);
		// fill the table past its end; the last load is dropped
		for (int i = 0; i < MAX_JOBS - 2; i++) begin
			row.rq = mk_req(FN_LOAD, 16'hF000 | 16'(i), 16'(i % 4 + 1));
			dir_tbl.push_back(row);
		end
		row.rq = mk_req(FN_STEP, 16'h0000, 16'h0000);
		dir_tbl.push_back(row);
		row.rq = mk_req(FN_CLEAR, 16'h5555, 16'hAAAA);
		dir_tbl.push_back(row);
		row.fixed = 1'b1;
		row.want = idle_rsp();
		row.rq = mk_req(FN_STEP, 16'h0000, 16'h0000);  // step after restart
		dir_tbl.push_back(row);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tbl[i])
			send_req(dir_tbl[i].rq, dir_tbl[i].fixed, dir_tbl[i].want);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			unique case (p)
				0: qv = '0;                          // zero runs as one
				1: qv = 16'd1;
				2: qv = 16'hFFFF;
				3: qv = 16'($urandom_range(0, 65535));
				default: qv = 16'($urandom_range(2, 12));
			endcase
			write_quantum(qv);
			qe = (qv == 0) ? 1 : 32'(qv);
			calm = (p % 3 == 2);
			phase_start = items_sent;
			while (items_sent - phase_start < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: any code, any fields
					repeat ($urandom_range(1, 4))
						send(mk_req(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom)));
				end else begin
					// well-formed job set: restart, load, step to completion
					send(mk_req(FN_CLEAR, 16'($urandom), 16'($urandom)));
					n_load = $urandom_range(1, MAX_JOBS);
					if ($urandom_range(0, 7) == 0)
						n_load = $urandom_range(MAX_JOBS, MAX_JOBS + 2);
					need = 0;
					for (int i = 0; i < n_load; i++) begin
						b = pick_burst(qe);
						send(mk_req(FN_LOAD, 16'($urandom), b));
						if (i < MAX_JOBS)
							need += (b + qe - 1) / qe;
					end
					n_step = need + $urandom_range(0, 2);
					if (n_step > STEP_CAP)
						n_step = STEP_CAP;
					// broken set: cut short
					if ($urandom_range(0, 5) == 0)
						n_step = $urandom_range(0, n_step);
					for (int s = 0; s < n_step; s++) begin
						if ($urandom_range(0, 29) == 0)
							send(mk_req(FN_UNUSED, 16'($urandom), 16'($urandom)));
						// late load joins the rotation at its slot
						if (s == n_step / 2 && $urandom_range(0, 3) == 0)
							send(mk_req(FN_LOAD, 16'($urandom), pick_burst(qe)));
						send(mk_req(FN_STEP, 16'($urandom), 16'($urandom)));
					end
				end
			end
			// sender pauses until the phase has fully drained
			drain();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
